// ===== hw/rtl/bmm_pkg.sv =====
package bmm_pkg;

    localparam int VERT_W = 6;
    localparam int CNT_W  = 7;

    localparam logic REG_U_COUNT = 1'b0;
    localparam logic REG_V_COUNT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GR_X,
        S_GR_E,
        S_GR_ED,
        S_LY_INIT,
        S_LY_Q,
        S_LY_H,
        S_LY_HD,
        S_LY_E,
        S_LY_ED,
        S_LY_PA,
        S_LY_PD,
        S_AUG_INIT,
        S_AUG_I,
        S_EX_A,
        S_EX_B,
        S_EX_C,
        S_EX_D,
        S_EX_APPLY,
        S_EX_AD,
        S_SZ,
        S_EM_A,
        S_EM_B,
        S_EM_C
    } t_state;

    typedef struct packed {
        logic [VERT_W-1:0] out_right;
        logic [VERT_W-1:0] out_left;
        logic              out_matched;
        logic [CNT_W-1:0]  out_size;
        logic              last;
    } t_res;

    function automatic logic [CNT_W-1:0] f_clamp(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] m);
        logic [CNT_W-1:0] res;
        begin
            if (v == '0) begin
                res = CNT_W'(1);
            end else if (v > m) begin
                res = m;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

// ===== hw/rtl/bipartite_max_matching_core.sv =====
// edge add transaction: accepted while idle, one per cycle back to back
// solve transaction: input stalls for the whole graph walk: a greedy pass over the edges,
//   then layering rounds, each followed by path search and path apply, then sizing
//   and emission of one result per right vertex
// results leave through one output register, loaded from S_EM_C after sizing ends
// reset (synchronous, active low) empties the edge store and matching, counts go to 64
module bipartite_max_matching_core import bmm_pkg::*; #(
    parameter int MAX_LEFT  = 64,
    parameter int MAX_RIGHT = 64,
    parameter int MAX_EDGES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [VERT_W-1:0] i_left_vertex,
    input  logic [VERT_W-1:0] i_right_vertex,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VERT_W-1:0] o_out_right,
    output logic [VERT_W-1:0] o_out_left,
    output logic              o_out_matched,
    output logic [CNT_W-1:0]  o_out_size,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_data
);
    localparam int LW  = $clog2(MAX_LEFT);
    localparam int RW  = $clog2(MAX_RIGHT);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam logic [CNT_W-1:0] MAXL = CNT_W'(MAX_LEFT);
    localparam logic [CNT_W-1:0] MAXR = CNT_W'(MAX_RIGHT);
    localparam logic [ECW-1:0]   MAXE = ECW'(MAX_EDGES);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_u_cnt, r_v_cnt;
    logic [ECW-1:0]   r_etot, n_etot, r_e, n_e;
    logic [CNT_W-1:0] r_x, n_x, r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0] r_i, n_i, r_depth, n_depth, r_k, n_k, r_size, n_size;
    logic [VERT_W-1:0] r_y, n_y;
    logic r_found, n_found;
    logic [MAX_RIGHT-1:0] r_pv, n_pv, r_rv, n_rv;
    logic [MAX_LEFT-1:0]  r_lv, n_lv, r_free, n_free;

    // memory ports
    logic [2*VERT_W-1:0] ed_data, st_rdata, st_wdata;
    logic                e_we, p_we, rb_we, lb_we, q_we, st_we;
    logic [VERT_W-1:0]   p_wa, p_wd, p_rd, rb_wa, rb_wd, rb_rd, lb_wa, lb_wd, lb_rd;
    logic [VERT_W-1:0]   q_wd, q_rd;
    logic [VERT_W-1:0]   ed_l, ed_r, st_y, st_x;
    logic                acc, usable;

    logic out_load, can_load;
    t_res out_d, out_q;

    assign ed_l = ed_data[2*VERT_W-1:VERT_W];
    assign ed_r = ed_data[VERT_W-1:0];
    assign st_y = st_rdata[2*VERT_W-1:VERT_W];
    assign st_x = st_rdata[VERT_W-1:0];
    assign usable = ({1'b0, ed_l} < r_u_cnt) && ({1'b0, ed_r} < r_v_cnt);
    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid && !o_stall;

    bmm_ram #(.WIDTH(2*VERT_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(r_etot[EAW-1:0]),
        .i_wdata({i_left_vertex, i_right_vertex}), .i_raddr(r_e[EAW-1:0]),
        .o_rdata(ed_data));

    bmm_ram #(.WIDTH(VERT_W), .DEPTH(MAX_RIGHT)) u_partner_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa[RW-1:0]), .i_wdata(p_wd),
        .i_raddr(r_y[RW-1:0]), .o_rdata(p_rd));

    bmm_ram #(.WIDTH(VERT_W), .DEPTH(MAX_RIGHT)) u_rlink_ram (
        .i_clk(i_clk), .i_we(rb_we), .i_waddr(rb_wa[RW-1:0]), .i_wdata(rb_wd),
        .i_raddr(r_y[RW-1:0]), .o_rdata(rb_rd));

    bmm_ram #(.WIDTH(VERT_W), .DEPTH(MAX_LEFT)) u_llink_ram (
        .i_clk(i_clk), .i_we(lb_we), .i_waddr(lb_wa[LW-1:0]), .i_wdata(lb_wd),
        .i_raddr(r_x[LW-1:0]), .o_rdata(lb_rd));

    bmm_ram #(.WIDTH(VERT_W), .DEPTH(MAX_LEFT)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(r_tail[LW-1:0]), .i_wdata(q_wd),
        .i_raddr(r_head[LW-1:0]), .o_rdata(q_rd));

    bmm_ram #(.WIDTH(2*VERT_W), .DEPTH(MAX_RIGHT)) u_stack_ram (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(r_depth[RW-1:0]), .i_wdata(st_wdata),
        .i_raddr(r_k[RW-1:0]), .o_rdata(st_rdata));

    bmm_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(out_load), .i_res(out_d),
        .i_stall(i_stall), .o_can_load(can_load), .o_valid(o_valid), .o_res(out_q));

    assign o_out_right   = out_q.out_right;
    assign o_out_left    = out_q.out_left;
    assign o_out_matched = out_q.out_matched;
    assign o_out_size    = out_q.out_size;
    assign o_last        = out_q.last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (acc && i_cmd) n_state = S_GR_X;
            S_GR_X:     n_state = (r_x == r_u_cnt) ? S_LY_INIT : S_GR_E;
            S_GR_E:     n_state = (r_e == r_etot) ? S_GR_X : S_GR_ED;
            S_GR_ED: begin
                if ({1'b0, ed_l} == r_x && usable && !r_pv[ed_r[RW-1:0]]) begin
                    n_state = S_GR_X;
                end else begin
                    n_state = S_GR_E;
                end
            end
            S_LY_INIT:  n_state = S_LY_Q;
            S_LY_Q:     if (r_x == r_u_cnt) n_state = S_LY_H;
            S_LY_H:     n_state = (r_head == r_tail) ? S_AUG_INIT : S_LY_HD;
            S_LY_HD:    n_state = S_LY_E;
            S_LY_E:     n_state = (r_e == r_etot) ? S_LY_H : S_LY_ED;
            S_LY_ED: begin
                if ({1'b0, ed_l} == r_x && usable && r_pv[ed_r[RW-1:0]]) begin
                    n_state = S_LY_PA;
                end else begin
                    n_state = S_LY_E;
                end
            end
            S_LY_PA:    n_state = S_LY_PD;
            S_LY_PD:    n_state = S_LY_E;
            S_AUG_INIT: n_state = S_AUG_I;
            S_AUG_I: begin
                if (r_i == r_v_cnt) begin
                    n_state = r_found ? S_LY_INIT : S_SZ;
                end else if (!r_pv[r_i[RW-1:0]]) begin
                    n_state = S_EX_A;
                end
            end
            S_EX_A:     n_state = r_rv[r_y[RW-1:0]] ? S_EX_B : S_AUG_I;
            S_EX_B:     n_state = S_EX_C;
            S_EX_C:     n_state = S_EX_D;
            S_EX_D: begin
                if (r_depth == MAXR) begin
                    n_state = S_AUG_I;
                end else if (r_free[r_x[LW-1:0]]) begin
                    n_state = S_EX_APPLY;
                end else if (!r_lv[r_x[LW-1:0]]) begin
                    n_state = S_AUG_I;
                end else begin
                    n_state = S_EX_A;
                end
            end
            S_EX_APPLY: n_state = (r_k == r_depth) ? S_AUG_I : S_EX_AD;
            S_EX_AD:    n_state = S_EX_APPLY;
            S_SZ:       if (r_i == r_v_cnt) n_state = S_EM_A;
            S_EM_A:     n_state = (r_i == r_v_cnt) ? S_IDLE : S_EM_B;
            S_EM_B:     n_state = S_EM_C;
            S_EM_C:     if (can_load) n_state = S_EM_A;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_etot = r_etot; n_e = r_e; n_x = r_x; n_head = r_head; n_tail = r_tail;
        n_i = r_i; n_depth = r_depth; n_k = r_k; n_size = r_size; n_y = r_y;
        n_found = r_found; n_pv = r_pv; n_rv = r_rv; n_lv = r_lv; n_free = r_free;
        e_we = 1'b0; p_we = 1'b0; rb_we = 1'b0; lb_we = 1'b0; q_we = 1'b0; st_we = 1'b0;
        p_wa = ed_r; p_wd = r_x[VERT_W-1:0];
        rb_wa = ed_r; rb_wd = r_x[VERT_W-1:0];
        lb_wa = p_rd; lb_wd = r_y;
        q_wd = r_x[VERT_W-1:0];
        st_wdata = {r_y, r_x[VERT_W-1:0]};
        out_load = 1'b0;
        out_d.out_right   = r_i[VERT_W-1:0];
        out_d.out_left    = r_pv[r_y[RW-1:0]] ? p_rd : '0;
        out_d.out_matched = r_pv[r_y[RW-1:0]];
        out_d.out_size    = r_size;
        out_d.last        = (r_i + CNT_W'(1) == r_v_cnt);
        case (r_state)
            S_IDLE: begin
                if (acc && !i_cmd) begin
                    if ({1'b0, i_left_vertex} < r_u_cnt && {1'b0, i_right_vertex} < r_v_cnt
                        && r_etot < MAXE) begin
                        e_we = 1'b1;
                        n_etot = r_etot + ECW'(1);
                    end
                end else if (acc) begin
                    n_x = '0;
                end
            end
            S_GR_X: n_e = '0;
            S_GR_E: if (r_e == r_etot) n_x = r_x + CNT_W'(1);
            S_GR_ED: begin
                n_e = r_e + ECW'(1);
                if ({1'b0, ed_l} == r_x && usable && !r_pv[ed_r[RW-1:0]]) begin
                    p_we = 1'b1;
                    n_pv[ed_r[RW-1:0]] = 1'b1;
                    n_free[r_x[LW-1:0]] = 1'b0;
                    n_x = r_x + CNT_W'(1);
                end
            end
            S_LY_INIT: begin
                n_lv = '0; n_rv = '0; n_x = '0; n_tail = '0; n_head = '0;
            end
            S_LY_Q: begin
                if (r_x != r_u_cnt) begin
                    if (r_free[r_x[LW-1:0]]) begin
                        q_we = 1'b1;
                        n_tail = r_tail + CNT_W'(1);
                    end
                    n_x = r_x + CNT_W'(1);
                end
            end
            S_LY_HD: begin
                n_x = {1'b0, q_rd};
                n_head = r_head + CNT_W'(1);
                n_e = '0;
            end
            S_LY_ED: begin
                n_e = r_e + ECW'(1);
                n_y = ed_r;
                if ({1'b0, ed_l} == r_x && usable) begin
                    if (!r_rv[ed_r[RW-1:0]]) begin
                        rb_we = 1'b1;
                        n_rv[ed_r[RW-1:0]] = 1'b1;
                    end
                end
            end
            S_LY_PD: begin
                // partner of this right vertex joins the next layer
                if (!r_lv[p_rd[LW-1:0]]) begin
                    lb_we = 1'b1;
                    n_lv[p_rd[LW-1:0]] = 1'b1;
                    if (r_tail < MAXL) begin
                        q_we = 1'b1;
                        q_wd = p_rd;
                        n_tail = r_tail + CNT_W'(1);
                    end
                end
            end
            S_AUG_INIT: begin
                n_i = '0; n_found = 1'b0;
            end
            S_AUG_I: begin
                if (r_i != r_v_cnt) begin
                    if (r_pv[r_i[RW-1:0]]) begin
                        n_i = r_i + CNT_W'(1);
                    end else begin
                        n_y = r_i[VERT_W-1:0];
                        n_depth = '0;
                    end
                end else begin
                    n_i = '0; n_size = '0;
                end
            end
            S_EX_A: if (!r_rv[r_y[RW-1:0]]) n_i = r_i + CNT_W'(1);
            S_EX_B: n_x = {1'b0, rb_rd};
            S_EX_D: begin
                n_rv[r_y[RW-1:0]] = 1'b0;
                n_lv[r_x[LW-1:0]] = 1'b0;
                if (r_depth == MAXR) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    st_we = 1'b1;
                    n_depth = r_depth + CNT_W'(1);
                    n_k = '0;
                    if (r_free[r_x[LW-1:0]]) begin
                        n_k = '0;
                    end else if (!r_lv[r_x[LW-1:0]]) begin
                        n_i = r_i + CNT_W'(1);
                    end else begin
                        n_y = lb_rd;
                    end
                end
            end
            S_EX_APPLY: begin
                if (r_k == r_depth) begin
                    n_found = 1'b1;
                    n_i = r_i + CNT_W'(1);
                end
            end
            S_EX_AD: begin
                p_we = 1'b1;
                p_wa = st_y;
                p_wd = st_x;
                n_pv[st_y[RW-1:0]] = 1'b1;
                n_free[st_x[LW-1:0]] = 1'b0;
                n_k = r_k + CNT_W'(1);
            end
            S_SZ: begin
                if (r_i != r_v_cnt) begin
                    n_size = r_size + CNT_W'(r_pv[r_i[RW-1:0]]);
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_i = '0;
                end
            end
            S_EM_A: begin
                if (r_i == r_v_cnt) begin
                    // drop the graph and matching for the next problem
                    n_etot = '0; n_pv = '0; n_lv = '0; n_rv = '0; n_free = '1;
                end else begin
                    n_y = r_i[VERT_W-1:0];
                end
            end
            S_EM_C: begin
                if (can_load) begin
                    out_load = 1'b1;
                    n_i = r_i + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_u_cnt <= f_clamp(CNT_W'(64), MAXL);
            r_v_cnt <= f_clamp(CNT_W'(64), MAXR);
            r_etot  <= '0;
            r_pv    <= '0;
            r_rv    <= '0;
            r_lv    <= '0;
            r_free  <= '1;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_etot  <= n_etot;
            r_pv    <= n_pv;
            r_rv    <= n_rv;
            r_lv    <= n_lv;
            r_free  <= n_free;
            r_found <= n_found;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_U_COUNT: r_u_cnt <= f_clamp(i_cfg_data, MAXL);
                    REG_V_COUNT: r_v_cnt <= f_clamp(i_cfg_data, MAXR);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_x     <= n_x;
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_i     <= n_i;
        r_depth <= n_depth;
        r_k     <= n_k;
        r_size  <= n_size;
        r_y     <= n_y;
    end
endmodule

// ===== hw/rtl/bmm_ram.sv =====
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/bmm_out_reg.sv =====
module bmm_out_reg import bmm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_res i_res,
    input  logic i_stall,
    output logic o_can_load,
    output logic o_valid,
    output t_res o_res
);
    logic r_valid;
    t_res r_res;

    assign o_can_load = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== hw/rtl/bmm_checker.sv =====
module bmm_checker import bmm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_cmd,
    input logic              o_valid,
    input logic              i_stall,
    input logic [VERT_W-1:0] o_out_right,
    input logic [VERT_W-1:0] o_out_left,
    input logic              o_out_matched,
    input logic [CNT_W-1:0]  o_out_size
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_right) && $stable(o_out_left))
        else $error("stalled result changed");

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_matched |-> o_out_left == '0)
        else $error("unmatched result carries a partner");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_size <= CNT_W'(64))
        else $error("matching size out of range");

    a_solve_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_cmd |=> o_stall)
        else $error("solve transaction did not stall input");

    a_matched_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_matched |-> o_out_size != '0)
        else $error("matched vertex with zero size");
endmodule

bind bipartite_max_matching_core bmm_checker u_bmm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_cmd(i_cmd), .o_valid(o_valid), .i_stall(i_stall), .o_out_right(o_out_right),
    .o_out_left(o_out_left), .o_out_matched(o_out_matched), .o_out_size(o_out_size));

// ===== tb/tb.sv =====
module tb;
    import bmm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NL = 64;
    localparam int NR = 64;
    localparam int NE = 1024;
    localparam logic [6:0] NO_LINK = 7'h7F;
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_cmd = CMD_ADD;
    logic [VERT_W-1:0] i_left_vertex = '0;
    logic [VERT_W-1:0] i_right_vertex = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [VERT_W-1:0] o_out_right;
    logic [VERT_W-1:0] o_out_left;
    logic              o_out_matched;
    logic [CNT_W-1:0]  o_out_size;
    logic              o_last;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = REG_U_COUNT;
    logic [CNT_W-1:0]  i_cfg_data = '0;

    bipartite_max_matching_core u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // matcher state kept by the testbench
    int unsigned       n_left, n_right, n_edges;
    logic [5:0]        e_l[NE];
    logic [5:0]        e_r[NE];
    logic [6:0]        mate_r[NR];
    bit                free_l[NL];
    logic [6:0]        link_l[NL];
    logic [6:0]        link_r[NR];
    t_res              pending_q[$];
    int                errors = 0;
    bit                hold_long = 1'b0;
    bit                no_gaps = 1'b0;

    function automatic int unsigned sat_count(logic [6:0] v, int unsigned m);
        if (v == 0) return 1;
        if (v > m) return m;
        return v;
    endfunction

    function automatic bit edge_ok(int e);
        return e_l[e] < n_left && e_r[e] < n_right;
    endfunction

    function automatic void reset_matching();
        for (int i = 0; i < NR; i++) begin
            mate_r[i] = NO_LINK;
            link_r[i] = NO_LINK;
        end
        for (int i = 0; i < NL; i++) begin
            free_l[i] = 1'b1;
            link_l[i] = NO_LINK;
        end
    endfunction

    function automatic void build_layers();
        int q[$];
        int x, y, w;
        for (int i = 0; i < NL; i++) link_l[i] = NO_LINK;
        for (int i = 0; i < NR; i++) link_r[i] = NO_LINK;
        for (int i = 0; i < n_left; i++) if (free_l[i] && q.size() < NL) q = {q, i};
        for (int h = 0; h < q.size(); h++) begin
            x = q[h];
            for (int e = 0; e < n_edges; e++) begin
                if (e_l[e] != x || !edge_ok(e)) continue;
                y = int'(e_r[e]);
                w = int'(mate_r[y]);
                if (link_r[y] == NO_LINK) link_r[y] = 7'(x);
                if (w < NL && link_l[w] == NO_LINK) begin
                    link_l[w] = 7'(y);
                    if (q.size() < NL) q = {q, w};
                end
            end
        end
    endfunction

    function automatic bit walk_path(int y);
        int rs[$];
        int ls[$];
        int x, w;
        forever begin
            if (y >= NR || link_r[y] == NO_LINK) return 0;
            x = int'(link_r[y]);
            if (x >= NL) return 0;
            w = int'(link_l[x]);
            link_r[y] = NO_LINK;
            link_l[x] = NO_LINK;
            if (rs.size() >= NR) return 0;
            rs = {rs, y};
            ls = {ls, x};
            if (free_l[x]) break;
            if (w == NO_LINK) return 0;
            y = w;
        end
        foreach (rs[i]) begin
            mate_r[rs[i]] = 7'(ls[i]);
            free_l[ls[i]] = 1'b0;
        end
        return 1;
    endfunction

    function automatic void predict_matching();
        bit found;
        int sz;
        t_res r;
        for (int x = 0; x < n_left; x++)
            for (int e = 0; e < n_edges; e++) begin
                if (e_l[e] != x || !edge_ok(e)) continue;
                if (mate_r[e_r[e]] != NO_LINK) continue;
                mate_r[e_r[e]] = 7'(x);
                free_l[x] = 1'b0;
                break;
            end
        do begin
            found = 0;
            build_layers();
            for (int i = 0; i < n_right; i++)
                if (mate_r[i] == NO_LINK) found |= walk_path(i);
        end while (found);
        sz = 0;
        for (int i = 0; i < n_right; i++) if (mate_r[i] != NO_LINK) sz++;
        for (int i = 0; i < n_right; i++) begin
            r.out_right   = 6'(i);
            r.out_matched = mate_r[i] != NO_LINK;
            r.out_left    = r.out_matched ? mate_r[i][5:0] : '0;
            r.out_size    = 7'(sz);
            r.last        = (i + 1 == n_right);
            pending_q = {pending_q, r};
        end
        n_edges = 0;
        reset_matching();
    endfunction

    task automatic send_item(logic c, logic [5:0] l, logic [5:0] r);
        i_valid        <= 1'b1;
        i_cmd          <= c;
        i_left_vertex  <= l;
        i_right_vertex <= r;
        do @(posedge i_clk); while (o_stall);
        if (c == CMD_SOLVE) predict_matching();
        else if (l < n_left && r < n_right && n_edges < NE) begin
            e_l[n_edges] = l;
            e_r[n_edges] = r;
            n_edges++;
        end
        @(negedge i_clk);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_U_COUNT) n_left = sat_count(v, NL);
        else n_right = sat_count(v, NR);
        @(negedge i_clk);
    endtask

    task automatic random_graph(int n, int ul, int vl);
        repeat (n)
            send_item(CMD_ADD, 6'($urandom_range(0, ul)), 6'($urandom_range(0, vl)));
        send_item(CMD_SOLVE, 6'($urandom), 6'($urandom));
    endtask

    task automatic test_directed();
        send_item(CMD_SOLVE, '0, '0);
        send_item(CMD_ADD, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd63, 6'd63);
        send_item(CMD_ADD, 6'd0, 6'd63);
        send_item(CMD_ADD, 6'd63, 6'd0);
        send_item(CMD_ADD, 6'd5, 6'd1);
        send_item(CMD_SOLVE, 6'd63, 6'd63);
        drain();
        write_reg(REG_U_COUNT, 7'd0);
        write_reg(REG_V_COUNT, 7'd127);
        send_item(CMD_ADD, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd1, 6'd1);
        send_item(CMD_SOLVE, '0, '0);
        drain();
        // augmenting chain that greedy gets wrong
        write_reg(REG_U_COUNT, 7'd3);
        write_reg(REG_V_COUNT, 7'd3);
        send_item(CMD_ADD, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd0, 6'd1);
        send_item(CMD_ADD, 6'd1, 6'd0);
        send_item(CMD_ADD, 6'd2, 6'd1);
        send_item(CMD_ADD, 6'd2, 6'd2);
        send_item(CMD_ADD, 6'd2, 6'd5);
        send_item(CMD_SOLVE, '0, '0);
        drain();
        // counts lowered after loading
        write_reg(REG_U_COUNT, 7'd64);
        write_reg(REG_V_COUNT, 7'd64);
        send_item(CMD_ADD, 6'd40, 6'd2);
        send_item(CMD_ADD, 6'd1, 6'd50);
        send_item(CMD_ADD, 6'd1, 6'd1);
        drain();
        write_reg(REG_U_COUNT, 7'd8);
        write_reg(REG_V_COUNT, 7'd8);
        send_item(CMD_SOLVE, '0, '0);
        drain();
    endtask

    task automatic test_random();
        int k;
        k = 0;
        while (k < 280) begin
            write_reg(REG_U_COUNT, 7'($urandom_range(1, 64)));
            write_reg(REG_V_COUNT, 7'($urandom_range(1, 64)));
            random_graph($urandom_range(2, 24), $urandom_range(1, 63), $urandom_range(1, 63));
            k += 15;
            drain();
        end
    endtask

    task automatic test_back_pressure();
        write_reg(REG_U_COUNT, 7'd64);
        write_reg(REG_V_COUNT, 7'd64);
        no_gaps = 1'b1;
        hold_long = 1'b1;
        random_graph(10, 63, 63);
        random_graph(10, 63, 63);
        no_gaps = 1'b0;
        drain();
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_long = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 7) < 2);
            end
        end
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result right=%0d", o_out_right);
            end else begin
                exp_r = pending_q.pop_front();
                if (exp_r.out_right !== o_out_right || exp_r.out_left !== o_out_left ||
                    exp_r.out_matched !== o_out_matched || exp_r.out_size !== o_out_size ||
                    exp_r.last !== o_last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                            exp_r.out_right, exp_r.out_left, exp_r.out_matched,
                            exp_r.out_size, exp_r.last, o_out_right, o_out_left,
                            o_out_matched, o_out_size, o_last);
                end
            end
        end
    end

    initial begin
        n_left = NL;
        n_right = NR;
        n_edges = 0;
        reset_matching();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        test_back_pressure();
        drain();
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== bipartite_max_matching_core.f =====
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_ram.sv
hw/rtl/bmm_out_reg.sv
hw/rtl/bipartite_max_matching_core.sv
hw/rtl/bmm_checker.sv
tb/tb.sv
